/* src/remote_command_frame_parser_macros.svh */
// ----------------------------------------------------------------------------
// Remote command frame parser assertion macros
// Shared helpers for the concurrent checks at the end of the queue and back end modules.
// ----------------------------------------------------------------------------
`ifndef REMOTE_COMMAND_FRAME_PARSER_MACROS_SVH
`define REMOTE_COMMAND_FRAME_PARSER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RCFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define RCFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/rcfp_pkg.sv */
// ----------------------------------------------------------------------------
// Remote command frame parser package
// Shared types, protocol constants and the fixed version reply frame.
// ----------------------------------------------------------------------------
`default_nettype none

package rcfp_pkg;

  // Kind of one result item.
  typedef enum logic {
    KindReply = 1'b0,
    KindWrite = 1'b1
  } kind_e;

  // One decoded frame handed from the parser to the emitter.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] addr;
    logic [7:0] value;
  } job_t;

  // Frame bytes.
  localparam logic [7:0] SyncByte   = 8'h55;
  localparam logic [7:0] ZeroByte   = 8'h00;
  localparam logic [7:0] TailByte   = 8'hAA;
  localparam logic [7:0] ReplyOrder = 8'h12;
  localparam logic [7:0] CheckBase  = 8'hFF;

  // Orders.
  localparam logic [7:0] OrderWriteA = 8'h00;
  localparam logic [7:0] OrderWriteB = 8'h01;
  localparam logic [7:0] OrderRead   = 8'h02;

  // Read addresses.
  localparam logic [7:0] AddrBattery = 8'h01;
  localparam logic [7:0] AddrWork    = 8'h02;
  localparam logic [7:0] AddrVersion = 8'h07;

  // Accepted write addresses.
  localparam logic [7:0] WrAddr03 = 8'h03;
  localparam logic [7:0] WrAddr30 = 8'h30;
  localparam logic [7:0] WrAddr32 = 8'h32;
  localparam logic [7:0] WrAddr3E = 8'h3E;

  // Length limits.
  localparam logic [7:0] MinFrameLen = 8'd7;
  localparam logic [7:0] MinReadLen  = 8'd8;
  localparam logic [7:0] MinWriteLen = 8'd9;

  // Reply frame geometry.
  localparam int unsigned IdxW          = 4;
  localparam logic [7:0]  ShortLenByte  = 8'h08;
  localparam logic [7:0]  VerLenByte    = 8'h0F;
  localparam logic [IdxW-1:0] ShortLast = 4'd8;
  localparam logic [IdxW-1:0] VerLast   = 4'd14;

  localparam logic [7:0] SpeedOffset = 8'd100;

  // The version reply never changes, checksum included.
  function automatic logic [7:0] version_byte(input logic [IdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = SyncByte;
      4'd1:    b = ZeroByte;
      4'd2:    b = VerLenByte;
      4'd3:    b = ReplyOrder;
      4'd4:    b = AddrVersion;
      4'd5:    b = 8'h50;
      4'd6:    b = 8'h2D;
      4'd7:    b = 8'h31;
      4'd8:    b = 8'h2E;
      4'd9:    b = 8'h30;
      4'd10:   b = 8'h2E;
      4'd11:   b = 8'h30;
      4'd12:   b = 8'h6D;
      4'd13:   b = ZeroByte;
      4'd14:   b = TailByte;
      default: b = ZeroByte;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/remote_command_frame_parser.sv */
// ----------------------------------------------------------------------------
// Remote command frame parser
// Decodes 55 00 framed remote commands and emits replies or write commands.
// ----------------------------------------------------------------------------
// Usage:
//   Packet bytes enter on the in_valid_i / in_ready_o channel, one request per
//   byte, with packet_end_i set on the last byte of a packet. Results leave on
//   the out_valid_o / out_ready_i channel, one request per reply byte or per
//   decoded write command; last_o marks the final result caused by one input.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets the battery
//   level (index 0) and the work state (index 1); write it only while idle.
// Throughput:
//   The parser takes one byte per cycle while the job queue has room. The
//   first result of a completed frame passes through the job queue and the
//   output register. The emitter gives one result per cycle while the
//   receiver is ready: 1 for a write, 9 or 15 for a reply.
// Reset and stalls:
//   Reset returns the parser to header hunting, empties the job queue and
//   restores battery level 100 and work state 1. When the receiver stalls,
//   the output register holds its result; the parser keeps taking bytes
//   until the job queue is full, and then drops in_ready_o.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_command_frame_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Received byte stream.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              packet_end_i,
  // Results.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   kind_o,
  output logic [7:0]             tx_byte_o,
  output logic [7:0]             write_addr_o,
  output logic [7:0]             write_value_o,
  output logic signed [7:0]      speed_o,
  output logic                   last_o,
  // Configuration writes.
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [6:0]        cfg_data_i
);

  // Register indexes of the configuration port.
  localparam logic CfgBattery = 1'b0;
  localparam logic CfgWork    = 1'b1;

  logic [6:0] battery_q;
  logic       work_q;

  // Config registers, read live by the emitter: the user must change them only
  // while idle (not enforced here), so a reply never sees a half-written value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      battery_q <= 7'd100;
      work_q    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBattery: battery_q <= cfg_data_i;
        CfgWork:    work_q    <= cfg_data_i[0];
        default:    battery_q <= battery_q;
      endcase
    end
  end

  logic           push, pop, full, empty;
  rcfp_pkg::job_t push_job, head_job;

  // Front end: header hunt, frame walk and checks. A good frame becomes one
  // job in the queue on the cycle its tail byte is accepted.
  rcfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .packet_end_i (packet_end_i),
    .full_i       (full),
    .push_o       (push),
    .push_job_o   (push_job)
  );

  // Job queue lets a long reply drain while the next frame is parsed.
  rcfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  // Back end: expands the head job into result items through an output
  // register; the job leaves the queue with its last result.
  rcfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_job),
    .empty_i       (empty),
    .pop_o         (pop),
    .battery_i     (battery_q),
    .work_i        (work_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .write_addr_o  (write_addr_o),
    .write_value_o (write_value_o),
    .speed_o       (speed_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

/* src/rcfp_front.sv */
// ----------------------------------------------------------------------------
// Remote command frame parser front end
// Hunts the header, walks the frame, checks tail and checksum, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             packet_end_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output rcfp_pkg::job_t        push_job_o
);

  typedef enum logic [4:0] {
    PhHunt  = 5'b00001,
    PhSaw55 = 5'b00010,
    PhLen   = 5'b00100,
    PhBody  = 5'b01000,
    PhDone  = 5'b10000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] len_q, len_d;
  logic [7:0] order_q, order_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] chk_q, chk_d;

  logic       accept;
  logic [7:0] chk_pos;
  logic       is_write_order;
  logic       write_addr_ok;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign chk_pos    = len_q - 8'd3;

  assign is_write_order = (order_q == rcfp_pkg::OrderWriteA) ||
                          (order_q == rcfp_pkg::OrderWriteB);
  assign write_addr_ok  = first_q inside {rcfp_pkg::WrAddr03, rcfp_pkg::WrAddr30,
                                          rcfp_pkg::WrAddr32, rcfp_pkg::WrAddr3E};

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    len_d      = len_q;
    order_d    = order_q;
    first_d    = first_q;
    second_d   = second_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    push_o     = 1'b0;
    push_job_o = '{kind: rcfp_pkg::KindReply, addr: first_q, value: second_q};

    if (accept) begin
      case (phase_q)
        PhHunt: begin
          if (rx_byte_i == rcfp_pkg::SyncByte) begin
            phase_d = PhSaw55;
          end
        end
        PhSaw55: begin
          if (rx_byte_i == rcfp_pkg::ZeroByte) begin
            phase_d = PhLen;
            count_d = 8'd2;
          end else if (rx_byte_i != rcfp_pkg::SyncByte) begin
            phase_d = PhHunt;
          end
        end
        PhLen: begin
          len_d = rx_byte_i;
          if (rx_byte_i < rcfp_pkg::MinFrameLen) begin
            phase_d = PhDone;
          end else begin
            sum_d   = rx_byte_i;
            count_d = 8'd3;
            phase_d = PhBody;
          end
        end
        PhBody: begin
          if (count_q == 8'd3) begin
            order_d = rx_byte_i;
            sum_d   = sum_q + rx_byte_i;
          end else if (count_q < chk_pos) begin
            if (count_q == 8'd4) begin
              first_d = rx_byte_i;
            end else if (count_q == 8'd5) begin
              second_d = rx_byte_i;
            end
            sum_d = sum_q + rx_byte_i;
          end else if (count_q == chk_pos) begin
            chk_d = rx_byte_i;
          end else if (count_q == chk_pos + 8'd1) begin
            if (rx_byte_i != rcfp_pkg::ZeroByte) begin
              phase_d = PhDone;
            end
          end else begin
            // Tail byte: the frame is complete, good or bad.
            if ((rx_byte_i == rcfp_pkg::TailByte) &&
                (chk_q == rcfp_pkg::CheckBase - sum_q)) begin
              if (order_q == rcfp_pkg::OrderRead) begin
                push_o = len_q >= rcfp_pkg::MinReadLen;
              end else if (is_write_order) begin
                push_o = (len_q >= rcfp_pkg::MinWriteLen) && write_addr_ok;
                push_job_o.kind = rcfp_pkg::KindWrite;
              end
            end
            phase_d = PhDone;
          end
          count_d = count_q + 8'd1;
        end
        PhDone: begin
          phase_d = PhDone;
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase

      if (packet_end_i) begin
        phase_d = PhHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      count_q  <= '0;
      len_q    <= '0;
      order_q  <= '0;
      first_q  <= '0;
      second_q <= '0;
      sum_q    <= '0;
      chk_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      len_q    <= len_d;
      order_q  <= order_d;
      first_q  <= first_d;
      second_q <= second_d;
      sum_q    <= sum_d;
      chk_q    <= chk_d;
    end
  end

endmodule

`default_nettype wire

/* src/rcfp_queue.sv */
// ----------------------------------------------------------------------------
// Remote command frame parser job queue
// Small FIFO of decoded frames between the parser and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "remote_command_frame_parser_macros.svh"

module rcfp_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rcfp_pkg::job_t  push_job_i,
  input  wire logic            pop_i,
  output logic                 full_o,
  output logic                 empty_o,
  output rcfp_pkg::job_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rcfp_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  `RCFP_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "job pushed into full queue")
  `RCFP_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "job popped from empty queue")
  `RCFP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth), "queue count beyond depth")

endmodule

`default_nettype wire

/* src/rcfp_back.sv */
// ----------------------------------------------------------------------------
// Remote command frame parser back end
// Turns queued jobs into reply bytes or writes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "remote_command_frame_parser_macros.svh"

module rcfp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rcfp_pkg::job_t  head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  input  wire logic [6:0]      battery_i,
  input  wire logic            work_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 kind_o,
  output logic [7:0]           tx_byte_o,
  output logic [7:0]           write_addr_o,
  output logic [7:0]           write_value_o,
  output logic signed [7:0]    speed_o,
  output logic                 last_o
);

  logic [rcfp_pkg::IdxW-1:0] idx_q, idx_d;
  logic                      valid_q;
  rcfp_pkg::kind_e           kind_q;
  logic [7:0]                tx_q, addr_q, value_q, speed_q;
  logic                      last_q;

  logic                      advance, step, is_last, is_write;
  logic [rcfp_pkg::IdxW-1:0] last_idx;
  logic [7:0]                data_byte, short_chk, short_byte, reply_byte;
  logic [15:0]               prod;
  logic [16:0]               quot_sum;
  logic [7:0]                speed_val;

  assign is_write = head_i.kind == rcfp_pkg::KindWrite;
  assign last_idx = is_write ? '0 :
                    (head_i.addr == rcfp_pkg::AddrVersion) ? rcfp_pkg::VerLast :
                    rcfp_pkg::ShortLast;
  assign is_last  = idx_q == last_idx;
  assign advance  = !valid_q || out_ready_i;
  assign step     = advance && !empty_i;
  assign pop_o    = step && is_last;
  assign idx_d    = step ? (is_last ? '0 : idx_q + 1'b1) : idx_q;

  // Nine-byte status reply, or the fixed version reply for the version address.
  always_comb begin
    if (head_i.addr == rcfp_pkg::AddrBattery) begin
      data_byte = {1'b0, battery_i};
    end else if (head_i.addr == rcfp_pkg::AddrWork) begin
      data_byte = {7'd0, work_i};
    end else begin
      data_byte = '0;
    end
    short_chk = rcfp_pkg::CheckBase - rcfp_pkg::ShortLenByte - rcfp_pkg::ReplyOrder -
                head_i.addr - data_byte;
    case (idx_q)
      4'd0:    short_byte = rcfp_pkg::SyncByte;
      4'd1:    short_byte = rcfp_pkg::ZeroByte;
      4'd2:    short_byte = rcfp_pkg::ShortLenByte;
      4'd3:    short_byte = rcfp_pkg::ReplyOrder;
      4'd4:    short_byte = head_i.addr;
      4'd5:    short_byte = data_byte;
      4'd6:    short_byte = short_chk;
      4'd7:    short_byte = rcfp_pkg::ZeroByte;
      4'd8:    short_byte = rcfp_pkg::TailByte;
      default: short_byte = rcfp_pkg::ZeroByte;
    endcase
    reply_byte = (head_i.addr == rcfp_pkg::AddrVersion) ?
                 rcfp_pkg::version_byte(idx_q) : short_byte;
  end

  // Speed is -100 + floor(200 * value / 255); the divide by 255 uses the
  // (x + (x >> 8) + 1) >> 8 identity, exact for x below 65535.
  assign prod      = {1'b0, head_i.value, 7'd0} + {2'b0, head_i.value, 6'd0} +
                     {5'b0, head_i.value, 3'd0};
  assign quot_sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
  assign speed_val = quot_sum[15:8] - rcfp_pkg::SpeedOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (advance) begin
        valid_q <= !empty_i;
      end
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      kind_q  <= head_i.kind;
      last_q  <= is_last;
      tx_q    <= is_write ? '0 : reply_byte;
      addr_q  <= is_write ? head_i.addr : '0;
      value_q <= is_write ? head_i.value : '0;
      speed_q <= is_write ? speed_val : '0;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign tx_byte_o     = tx_q;
  assign write_addr_o  = addr_q;
  assign write_value_o = value_q;
  assign speed_o       = speed_q;
  assign last_o        = last_q;

  `RCFP_ASSERT(a_write_is_last, clk_i, rst_ni, (valid_q && kind_q == rcfp_pkg::KindWrite) |-> last_q, "write command not marked last")
  `RCFP_ASSERT(a_reply_ends_tail, clk_i, rst_ni, (valid_q && kind_q == rcfp_pkg::KindReply && last_q) |-> (tx_q == rcfp_pkg::TailByte), "reply frame ends without tail")
  `RCFP_ASSERT(a_idx_bound, clk_i, rst_ni, idx_q <= rcfp_pkg::VerLast, "reply index past longest frame")

endmodule

`default_nettype wire

/* test/remote_command_frame_parser_tb.sv */
// ----------------------------------------------------------------------------
// Remote command frame parser testbench
// Feeds framed command packets through the byte channel and checks every reply byte
// and decoded write command against a cycle-free behavioral model or the directed plan.
// ----------------------------------------------------------------------------
module remote_command_frame_parser_tb;

  // Configuration register indexes on the write port.
  localparam logic CfgBattery = 1'b0;
  localparam logic CfgWork    = 1'b1;

  // Idle cycles allowed after the last expected result before the block is
  // considered quiet. A frame that causes no result may still be in the
  // parser, and a reply of up to 15 bytes may still be leaving the emitter.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomBytes  = 200;

  // Version text carried in the long reply, first character in the top byte.
  localparam logic [55:0] VersionText = "P-1.0.0";

  // Parser phases of the behavioral model.
  typedef enum logic [2:0] {
    ParseHunt,
    ParseSync,
    ParseLength,
    ParseBody,
    ParseSkip
  } parse_phase_e;

  // Ways in which a stimulus frame can be damaged or framed oddly.
  typedef enum logic [2:0] {
    FlawNone,
    FlawChecksum,
    FlawTail,
    FlawZero,
    FlawCut,
    FlawDoubleSync,
    FlawTrailing
  } flaw_e;

  // One result as seen on the output channel.
  typedef struct {
    rcfp_pkg::kind_e kind;
    logic [7:0]      tx;
    logic [7:0]      addr;
    logic [7:0]      value;
    logic [7:0]      speed;
    logic            last;
  } result_t;

  // One row of the directed plan. A want_n of -1 leaves the expectation to
  // the model; 0 or 1 gives the expected outcome directly.
  typedef struct {
    logic [7:0] len;
    logic [7:0] order;
    logic [7:0] addr;
    logic [7:0] value;
    flaw_e      flaw;
    int         want_n;
    logic [7:0] want_value;
    int         want_speed;
  } frame_row_t;

  // DUT connections.
  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        rx_byte_i;
  logic              packet_end_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              kind_o;
  logic [7:0]        tx_byte_o;
  logic [7:0]        write_addr_o;
  logic [7:0]        write_value_o;
  logic signed [7:0] speed_o;
  logic              last_o;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [6:0]        cfg_data_i;

  // Behavioral model state and its copy of the configuration.
  parse_phase_e parse_phase;
  int unsigned  frame_pos;
  logic [7:0]   frame_len;
  logic [7:0]   order_seen;
  logic [7:0]   first_seen;
  logic [7:0]   second_seen;
  logic [7:0]   body_sum;
  logic [7:0]   check_seen;
  logic [6:0]   battery_model;
  logic         work_model;

  // Results caused by the byte just accepted, and all results still owed.
  result_t      frame_results[$];
  result_t      expected_results[$];

  // The packet being assembled for the byte channel.
  logic [7:0]   packet_bytes[$];

  // Run bookkeeping.
  bit           steady;
  bit           use_table_result;
  int unsigned  cycle_count;
  int unsigned  mismatches;
  int unsigned  bytes_fed;
  int unsigned  packets_fed;
  int unsigned  random_frame_bytes;
  int unsigned  results_checked;
  int unsigned  replies_seen;
  int unsigned  writes_seen;
  int unsigned  settings_applied;

  frame_row_t   directed_plan [0:20];

  remote_command_frame_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .packet_end_i  (packet_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .tx_byte_o     (tx_byte_o),
    .write_addr_o  (write_addr_o),
    .write_value_o (write_value_o),
    .speed_o       (speed_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral model
  // --------------------------------------------------------------------------

  // Turns a frame that passed its tail and checksum into results. Reads get a
  // reply frame, writes to one of the four known addresses get one decoded
  // command; everything else is accepted silently.
  function automatic void decode_frame();
    logic [7:0] f [15];
    logic [7:0] s;
    int         n;
    int         spd;
    result_t    r;
    if (order_seen == rcfp_pkg::OrderRead) begin
      if (frame_len < rcfp_pkg::MinReadLen) return;
      f[0] = rcfp_pkg::SyncByte;
      f[1] = rcfp_pkg::ZeroByte;
      f[3] = rcfp_pkg::ReplyOrder;
      f[4] = first_seen;
      if (first_seen == rcfp_pkg::AddrVersion) begin
        n    = 15;
        f[2] = rcfp_pkg::VerLenByte;
        for (int i = 0; i < 7; i++) f[5 + i] = VersionText[55 - 8 * i -: 8];
      end else begin
        n    = 9;
        f[2] = rcfp_pkg::ShortLenByte;
        if (first_seen == rcfp_pkg::AddrBattery) f[5] = {1'b0, battery_model};
        else if (first_seen == rcfp_pkg::AddrWork) f[5] = {7'd0, work_model};
        else f[5] = 8'h00;
      end
      // The reply checksum covers the length byte up to the last data byte.
      s = 8'h00;
      for (int i = 2; i < n - 3; i++) s = s + f[i];
      f[n - 3] = rcfp_pkg::CheckBase - s;
      f[n - 2] = rcfp_pkg::ZeroByte;
      f[n - 1] = rcfp_pkg::TailByte;
      for (int i = 0; i < n; i++) begin
        r.kind  = rcfp_pkg::KindReply;
        r.tx    = f[i];
        r.addr  = 8'h00;
        r.value = 8'h00;
        r.speed = 8'h00;
        r.last  = 1'b0;
        frame_results.push_back(r);
      end
    end else if (order_seen == rcfp_pkg::OrderWriteA ||
                 order_seen == rcfp_pkg::OrderWriteB) begin
      if (frame_len < rcfp_pkg::MinWriteLen) return;
      if (first_seen != rcfp_pkg::WrAddr30 && first_seen != rcfp_pkg::WrAddr32 &&
          first_seen != rcfp_pkg::WrAddr3E && first_seen != rcfp_pkg::WrAddr03) return;
      // Integer scaling of 0..255 onto -100..100, truncated.
      spd     = -100 + (200 * int'(second_seen)) / 255;
      r.kind  = rcfp_pkg::KindWrite;
      r.tx    = 8'h00;
      r.addr  = first_seen;
      r.value = second_seen;
      r.speed = spd[7:0];
      r.last  = 1'b0;
      frame_results.push_back(r);
    end
  endfunction

  // Advances the model by one accepted byte and leaves the results it causes
  // in frame_results, with the final one marked last.
  function automatic void predict_byte(input logic [7:0] b, input logic endp);
    int unsigned flen;
    flen = frame_len;
    frame_results.delete();
    case (parse_phase)
      ParseHunt: begin
        if (b == rcfp_pkg::SyncByte) parse_phase = ParseSync;
      end
      ParseSync: begin
        if (b == rcfp_pkg::ZeroByte) begin
          parse_phase = ParseLength;
          frame_pos   = 2;
        end else if (b != rcfp_pkg::SyncByte) begin
          parse_phase = ParseHunt;
        end
      end
      ParseLength: begin
        frame_len = b;
        if (b < rcfp_pkg::MinFrameLen) begin
          parse_phase = ParseSkip;
        end else begin
          body_sum    = b;
          frame_pos   = 3;
          parse_phase = ParseBody;
        end
      end
      ParseBody: begin
        if (frame_pos == 3) begin
          order_seen = b;
          body_sum   = body_sum + b;
        end else if (frame_pos + 3 < flen) begin
          if (frame_pos == 4) first_seen = b;
          else if (frame_pos == 5) second_seen = b;
          body_sum = body_sum + b;
        end else if (frame_pos + 3 == flen) begin
          check_seen = b;
        end else if (frame_pos + 2 == flen) begin
          if (b != rcfp_pkg::ZeroByte) parse_phase = ParseSkip;
        end else begin
          if (b == rcfp_pkg::TailByte &&
              check_seen == 8'(rcfp_pkg::CheckBase - body_sum)) decode_frame();
          parse_phase = ParseSkip;
        end
        frame_pos = frame_pos + 1;
      end
      default: ;
    endcase
    if (endp) parse_phase = ParseHunt;
    if (frame_results.size() != 0) frame_results[frame_results.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Assembles one frame into packet_bytes. The length byte counts the whole
  // frame, so the payload holds len-7 bytes; the first two carry the address
  // and the value, the rest is filler that still enters the checksum.
  function automatic void build_frame(input logic [7:0] len, input logic [7:0] order,
                                      input logic [7:0] addr, input logic [7:0] value,
                                      input flaw_e flaw);
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned pos;
    int unsigned keep;
    packet_bytes.delete();
    if (flaw == FlawDoubleSync) packet_bytes.push_back(rcfp_pkg::SyncByte);
    packet_bytes.push_back(rcfp_pkg::SyncByte);
    packet_bytes.push_back(rcfp_pkg::ZeroByte);
    packet_bytes.push_back(len);
    if (len < rcfp_pkg::MinFrameLen) begin
      // A short length rejects the frame; whatever follows is ignored.
      repeat (3) packet_bytes.push_back(8'($urandom));
    end else begin
      packet_bytes.push_back(order);
      sum = len + order;
      for (pos = 4; pos + 3 < len; pos++) begin
        b   = (pos == 4) ? addr : (pos == 5) ? value : 8'($urandom);
        sum = sum + b;
        packet_bytes.push_back(b);
      end
      b = rcfp_pkg::CheckBase - sum;
      if (flaw == FlawChecksum) b = b ^ (8'd1 << $urandom_range(0, 7));
      packet_bytes.push_back(b);
      packet_bytes.push_back((flaw == FlawZero) ? 8'($urandom_range(1, 255))
                                                : rcfp_pkg::ZeroByte);
      packet_bytes.push_back((flaw == FlawTail) ?
                             (rcfp_pkg::TailByte ^ 8'($urandom_range(1, 255))) :
                             rcfp_pkg::TailByte);
    end
    if (flaw == FlawCut) begin
      // The packet ends somewhere inside the frame.
      keep = $urandom_range(3, packet_bytes.size() - 1);
      while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
    end
    if (flaw == FlawTrailing) begin
      // A second, well formed battery read in the same packet must be ignored.
      sum = rcfp_pkg::ShortLenByte + rcfp_pkg::OrderRead + rcfp_pkg::AddrBattery;
      packet_bytes.push_back(rcfp_pkg::SyncByte);
      packet_bytes.push_back(rcfp_pkg::ZeroByte);
      packet_bytes.push_back(rcfp_pkg::ShortLenByte);
      packet_bytes.push_back(rcfp_pkg::OrderRead);
      packet_bytes.push_back(rcfp_pkg::AddrBattery);
      packet_bytes.push_back(rcfp_pkg::CheckBase - sum);
      packet_bytes.push_back(rcfp_pkg::ZeroByte);
      packet_bytes.push_back(rcfp_pkg::TailByte);
    end
  endfunction

  // Offers one byte after a random gap and returns at the edge that accepts
  // it. The model is stepped at that same edge, so its results are queued
  // before the block can present the first of them.
  task automatic push_byte(input logic [7:0] b, input logic endp);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rx_byte_i    <= b;
    packet_end_i <= endp;
    do @(posedge clk_i); while (!in_ready_o);
    predict_byte(b, endp);
    if (!use_table_result) begin
      foreach (frame_results[i]) expected_results.push_back(frame_results[i]);
    end
    bytes_fed++;
  endtask

  // Sends packet_bytes as one packet, the end mark on its last byte.
  task automatic send_packet();
    foreach (packet_bytes[i]) push_byte(packet_bytes[i], i == packet_bytes.size() - 1);
    packets_fed++;
  endtask

  // Holds the sender until every owed result has come out, then lets the
  // block sit for a while longer.
  task automatic drain_results(input int unsigned extra);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Writes both registers once the block is quiet. The work state word keeps
  // random upper bits, which the block must ignore.
  task automatic apply_settings(input logic [6:0] level, input logic [6:0] state_word);
    drain_results(SettleCycles);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgBattery;
    cfg_data_i <= level;
    @(posedge clk_i);
    cfg_idx_i  <= CfgWork;
    cfg_data_i <= state_word;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    battery_model = level;
    work_model    = state_word[0];
    settings_applied++;
  endtask

  // One random packet. Most are well formed reads and writes with random
  // content, so the parser gets past the header; the rest carry a damaged
  // checksum, tail or zero byte, a short length, an early packet end, or
  // noise around the frame.
  task automatic send_random_packet();
    int unsigned pick;
    logic [7:0]  len;
    logic [7:0]  order;
    logic [7:0]  addr;
    logic [7:0]  value;
    flaw_e       flaw;
    pick = $urandom_range(0, 9);
    if (pick <= 4) begin
      order = rcfp_pkg::OrderRead;
      case ($urandom_range(0, 3))
        0:       addr = rcfp_pkg::AddrBattery;
        1:       addr = rcfp_pkg::AddrWork;
        2:       addr = rcfp_pkg::AddrVersion;
        default: addr = 8'($urandom);
      endcase
      pick = $urandom_range(0, 9);
      len  = (pick == 0) ? rcfp_pkg::MinFrameLen :
             (pick <= 6) ? rcfp_pkg::MinReadLen :
                           rcfp_pkg::MinReadLen + 8'($urandom_range(1, 6));
    end else begin
      order = (pick <= 6) ? rcfp_pkg::OrderWriteA :
              (pick <= 8) ? rcfp_pkg::OrderWriteB : 8'($urandom_range(3, 255));
      case ($urandom_range(0, 4))
        0:       addr = rcfp_pkg::WrAddr03;
        1:       addr = rcfp_pkg::WrAddr30;
        2:       addr = rcfp_pkg::WrAddr32;
        3:       addr = rcfp_pkg::WrAddr3E;
        default: addr = 8'($urandom);
      endcase
      pick = $urandom_range(0, 9);
      len  = (pick == 0) ? rcfp_pkg::MinFrameLen :
             (pick == 1) ? rcfp_pkg::MinReadLen :
             (pick <= 6) ? rcfp_pkg::MinWriteLen :
                           rcfp_pkg::MinWriteLen + 8'($urandom_range(1, 6));
    end
    if ($urandom_range(0, 49) == 0) len = 8'($urandom_range(16, 60));
    case ($urandom_range(0, 7))
      0:       value = 8'h00;
      1:       value = 8'hFF;
      default: value = 8'($urandom);
    endcase
    pick = $urandom_range(0, 19);
    case (pick)
      14:      flaw = FlawChecksum;
      15:      flaw = FlawTail;
      16:      flaw = FlawZero;
      17:      flaw = FlawCut;
      18:      flaw = $urandom_range(0, 1) ? FlawDoubleSync : FlawTrailing;
      default: flaw = FlawNone;
    endcase
    if (pick == 19) len = 8'($urandom_range(0, 6));
    build_frame(len, order, addr, value, flaw);
    random_frame_bytes += packet_bytes.size();
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) packet_bytes.push_front(8'($urandom));
    end
    if (flaw != FlawCut && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) packet_bytes.push_back(8'($urandom));
    end
    send_packet();
  endtask

  // Random packets until the phase has sent its share of frame bytes. The
  // idle pattern changes now and then, and once in a while the sender waits
  // for the output channel to empty completely.
  task automatic run_random(input int unsigned share);
    int unsigned goal;
    goal = random_frame_bytes + share;
    while (random_frame_bytes < goal) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if ($urandom_range(0, 19) == 0) drain_results(2);
      send_random_packet();
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag_mismatch(input string msg);
    $display("cycle %0d: mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is %02h, expected %02h (result %0d)",
                              name, got, want, results_checked));
    end
  endtask

  // Every result taken by the receiver is matched with the oldest one owed.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result with none owed: kind %0d tx %02h addr %02h",
                                kind_o, tx_byte_o, write_addr_o));
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", 8'(kind_o), 8'(want.kind));
        compare_field("tx_byte", tx_byte_o, want.tx);
        compare_field("write_addr", write_addr_o, want.addr);
        compare_field("write_value", write_value_o, want.value);
        compare_field("speed", speed_o, want.speed);
        compare_field("last", 8'(last_o), 8'(want.last));
      end
      results_checked++;
      if (last_o && kind_o == rcfp_pkg::KindReply) replies_seen++;
      if (kind_o == rcfp_pkg::KindWrite) writes_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("remote_command_frame_parser verification failed");
      $finish;
    end
  end

  // Receiver: before each result it stays busy for a random number of cycles
  // (none while the run is in a steady stretch), then takes the next result.
  initial begin : result_sink
    int unsigned gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    frame_row_t row;
    result_t    r;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    rx_byte_i    = 8'h00;
    packet_end_i = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgBattery;
    cfg_data_i   = 7'd0;
    steady       = 1'b0;
    use_table_result = 1'b0;
    cycle_count  = 0;
    mismatches   = 0;
    bytes_fed    = 0;
    packets_fed  = 0;
    random_frame_bytes = 0;
    results_checked    = 0;
    replies_seen       = 0;
    writes_seen        = 0;
    settings_applied   = 0;

    // Model state after reset: hunting, battery 100, normal work state.
    parse_phase   = ParseHunt;
    frame_pos     = 0;
    frame_len     = 8'h00;
    order_seen    = 8'h00;
    first_seen    = 8'h00;
    second_seen   = 8'h00;
    body_sum      = 8'h00;
    check_seen    = 8'h00;
    battery_model = 7'd100;
    work_model    = 1'b1;

    // Directed plan. Reads right after reset check the reset values of both
    // registers through the model; writes at the value extremes and every
    // silent case carry their outcome in the row itself.
    //        len    order                 addr                  value  flaw   n value speed
    directed_plan = '{
      '{8'd8,  rcfp_pkg::OrderRead,   rcfp_pkg::AddrBattery, 8'h00, FlawNone, -1, 8'h00, 0},
      '{8'd8,  rcfp_pkg::OrderRead,   rcfp_pkg::AddrWork,    8'h00, FlawNone, -1, 8'h00, 0},
      '{8'd8,  rcfp_pkg::OrderRead,   rcfp_pkg::AddrVersion, 8'h00, FlawNone, -1, 8'h00, 0},
      '{8'd8,  rcfp_pkg::OrderRead,   8'hFF,                 8'h00, FlawNone, -1, 8'h00, 0},
      '{8'd9,  rcfp_pkg::OrderWriteA, rcfp_pkg::WrAddr30, 8'h00, FlawNone, 1, 8'h00, -100},
      '{8'd9,  rcfp_pkg::OrderWriteB, rcfp_pkg::WrAddr3E, 8'hFF, FlawNone, 1, 8'hFF,  100},
      '{8'd12, rcfp_pkg::OrderWriteA, rcfp_pkg::WrAddr32, 8'h80, FlawNone, 1, 8'h80,    0},
      '{8'd9,  rcfp_pkg::OrderWriteB, rcfp_pkg::WrAddr03, 8'h7F, FlawNone, 1, 8'h7F,   -1},
      // Unknown write address.
      '{8'd9,  rcfp_pkg::OrderWriteA, 8'h31,                 8'h10, FlawNone, 0, 8'h00, 0},
      // Read without a payload byte, write without a value byte.
      '{8'd7,  rcfp_pkg::OrderRead,   rcfp_pkg::AddrBattery, 8'h00, FlawNone, 0, 8'h00, 0},
      '{8'd8,  rcfp_pkg::OrderWriteA, rcfp_pkg::WrAddr30,    8'h00, FlawNone, 0, 8'h00, 0},
      // An order that is neither read nor write.
      '{8'd9,  8'hFF,                 rcfp_pkg::WrAddr30,    8'h00, FlawNone, 0, 8'h00, 0},
      // Length bytes below the minimum frame.
      '{8'd0,  rcfp_pkg::OrderRead,   rcfp_pkg::AddrBattery, 8'h00, FlawNone, 0, 8'h00, 0},
      '{8'd6,  rcfp_pkg::OrderRead,   rcfp_pkg::AddrBattery, 8'h00, FlawNone, 0, 8'h00, 0},
      // Damaged checksum, tail and zero byte, and a packet that ends early.
      '{8'd8,  rcfp_pkg::OrderRead, rcfp_pkg::AddrBattery, 8'h00, FlawChecksum, 0, 8'h00, 0},
      '{8'd8,  rcfp_pkg::OrderRead, rcfp_pkg::AddrBattery, 8'h00, FlawTail,     0, 8'h00, 0},
      '{8'd9,  rcfp_pkg::OrderWriteA, rcfp_pkg::WrAddr30,  8'h00, FlawZero,     0, 8'h00, 0},
      '{8'd9,  rcfp_pkg::OrderWriteA, rcfp_pkg::WrAddr30,  8'h00, FlawCut,      0, 8'h00, 0},
      // Repeated sync byte, a second frame in one packet, a long frame.
      '{8'd8,  rcfp_pkg::OrderRead, rcfp_pkg::AddrWork,  8'h00, FlawDoubleSync, -1, 8'h00, 0},
      '{8'd9,  rcfp_pkg::OrderWriteA, rcfp_pkg::WrAddr3E, 8'h40, FlawTrailing, -1, 8'h00, 0},
      '{8'd64, rcfp_pkg::OrderRead, rcfp_pkg::AddrVersion, 8'h00, FlawNone,     -1, 8'h00, 0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[k]) begin
      row = directed_plan[k];
      build_frame(row.len, row.order, row.addr, row.value, row.flaw);
      use_table_result = (row.want_n >= 0);
      send_packet();
      // The result of a table row is owed from the tail byte on, which was
      // accepted at this very edge, so it is queued in time.
      if (row.want_n == 1) begin
        r.kind  = rcfp_pkg::KindWrite;
        r.tx    = 8'h00;
        r.addr  = row.addr;
        r.value = row.want_value;
        r.speed = 8'(row.want_speed);
        r.last  = 1'b1;
        expected_results.push_back(r);
      end
      use_table_result = 1'b0;
    end

    // Random phases under different settings: both registers at zero, the
    // widest battery value with normal state, and then random values.
    apply_settings(7'd0, {6'($urandom), 1'b0});
    run_random(RandomBytes / 3);

    apply_settings(7'd127, {6'($urandom), 1'b1});
    steady = 1'b1;
    run_random(RandomBytes / 3);

    apply_settings(7'($urandom_range(0, 100)), 7'($urandom));
    steady = 1'b0;
    run_random(RandomBytes - 2 * (RandomBytes / 3));

    drain_results(SettleCycles);

    $display("Sent %0d bytes in %0d packets under %0d register settings.",
             bytes_fed, packets_fed, settings_applied + 1);
    $display("Checked %0d results: %0d reply frames and %0d write commands.",
             results_checked, replies_seen, writes_seen);
    if (mismatches == 0) begin
      $display("remote_command_frame_parser verification clean");
    end else begin
      $display("remote_command_frame_parser verification failed");
    end
    $finish;
  end

endmodule
